@@ src/damped_spring_force_defines.svh @@
// assertion macros for the spring force block
`ifndef DAMPED_SPRING_FORCE_DEFINES_SVH
`define DAMPED_SPRING_FORCE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define DSF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define DSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/dsf_pkg.sv @@
package dsf_pkg;

	// fixed widths of the datapath
	localparam int unsigned IN_W     = 32;
	localparam int unsigned D_W      = IN_W + 1;     // position and velocity differences
	localparam int unsigned SQ_W     = 2 * D_W - 1;  // one squared difference
	localparam int unsigned N_W      = SQ_W + 1;     // squared length
	localparam int unsigned DOT_W    = 2 * D_W + 1;  // d . w
	localparam int unsigned L_W      = N_W / 2;      // length
	localparam int unsigned SQ_N     = N_W / 2;      // root bits, one per stage
	localparam int unsigned SQ_REM_W = L_W + 1;
	localparam int unsigned RQ_W     = 35;           // |d . w| / L stays below 2^35
	localparam int unsigned FQ_W     = IN_W;         // force quotient bits
	localparam int unsigned CFG_W    = 31;

	localparam logic [FQ_W-1:0] FORCE_MAX = 32'h7fff_ffff;
	localparam logic [FQ_W-1:0] FORCE_MIN = 32'h8000_0000;

	localparam logic [CFG_W-1:0] REST_RESET  = 31'd65536;
	localparam logic [CFG_W-1:0] STIFF_RESET = 31'd65536;
	localparam logic [CFG_W-1:0] DAMP_RESET  = 31'd0;

	typedef enum logic [1:0] {
		REG_REST_LENGTH = 2'd0,
		REG_STIFFNESS   = 2'd1,
		REG_DAMPING     = 2'd2
	} reg_idx_t;

	typedef logic [2:0][D_W-1:0] dvec_t;

	// one stage of the square root unit
	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [L_W-1:0]      root;
		logic [N_W-1:0]      nsh;
		logic [DOT_W-1:0]    dot;
		dvec_t               d;
	} sqr_t;

	// one stage of the damping rate divider
	typedef struct packed {
		logic [L_W-1:0]  rem;
		logic [RQ_W-1:0] lo;
		logic [RQ_W-1:0] q;
		logic [L_W-1:0]  len;
		logic            neg;
		dvec_t           d;
	} rdv_t;

	// one lane of the force divider
	typedef struct packed {
		logic [L_W-1:0]  rem;
		logic [FQ_W-1:0] lo;
		logic [FQ_W-1:0] q;
		logic            ovf;
		logic            neg;
	} flane_t;

	typedef struct packed {
		flane_t [2:0]   ln;
		logic [L_W-1:0] len;
	} fdv_t;

endpackage

@@ src/damped_spring_force.sv @@
// a beat passes differences, squares, sums, square root, rate divider, products, force divider, clamp
// throughput: one beat per cycle unless the output stalls; the square root (one
// bit per stage) and the two restoring dividers (one quotient bit per stage) set the depth
// a stall on the output freezes the whole pipeline, nothing lost or repeated
// reset clears all valid bits and loads rest_length = stiffness = 1.0, damping = 0
`include "damped_spring_force_defines.svh"
module damped_spring_force
	import dsf_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// config port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_pos_x/y/z, second_pos_x/y/z, first_vel_x/y/z, second_vel_x/y/z
	input  logic [383:0] s_tdata,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// force_x, force_y, force_z
	output logic [95:0]  m_tdata,
	// zero_length, saturated
	output logic [1:0]   m_tuser
);

	localparam int unsigned PK_W  = CFG_W + 1 + L_W + 1;
	localparam int unsigned PD_W  = CFG_W + 1 + RQ_W + 1;
	localparam int unsigned ACC_W = PD_W + 1;
	localparam int unsigned S_W   = ACC_W - FRAC_BITS;
	localparam int unsigned SL    = S_W / 2;
	localparam int unsigned SH    = S_W - SL;
	localparam int unsigned P_W   = S_W + D_W;

	logic en;

	// config registers
	logic [CFG_W-1:0] rest_q, stiff_q, damp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q  <= REST_RESET;
			stiff_q <= STIFF_RESET;
			damp_q  <= DAMP_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_REST_LENGTH: rest_q  <= pwdata[CFG_W-1:0];
				REG_STIFFNESS:   stiff_q <= pwdata[CFG_W-1:0];
				REG_DAMPING:     damp_q  <= pwdata[CFG_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_REST_LENGTH: prdata = {1'b0, rest_q};
			REG_STIFFNESS:   prdata = {1'b0, stiff_q};
			REG_DAMPING:     prdata = {1'b0, damp_q};
			default:         prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// whole pipe moves unless the output beat is held
	logic out_vld_q;
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s5, v_s6, v_s7, v_s8;
	logic [SQ_N-1:0] sqr_v_s;
	logic [RQ_W-1:0] rdv_v_s;
	logic [FQ_W-1:0] fdv_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			sqr_v_s   <= '0;
			rdv_v_s   <= '0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			fdv_v_s   <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s1      <= s_tvalid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			sqr_v_s   <= {sqr_v_s[SQ_N-2:0], v_s3};
			rdv_v_s   <= {rdv_v_s[RQ_W-2:0], sqr_v_s[SQ_N-1]};
			v_s5      <= rdv_v_s[RQ_W-1];
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			fdv_v_s   <= {fdv_v_s[FQ_W-2:0], v_s8};
			out_vld_q <= fdv_v_s[FQ_W-1];
		end
	end

	// stage 1: differences
	dvec_t d_s1, w_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= D_W'(signed'(s_tdata[IN_W*i +: IN_W]))
					- D_W'(signed'(s_tdata[IN_W*(3+i) +: IN_W]));
				w_s1[i] <= D_W'(signed'(s_tdata[IN_W*(6+i) +: IN_W]))
					- D_W'(signed'(s_tdata[IN_W*(9+i) +: IN_W]));
			end
		end
	end

	// stage 2: squares and dot terms
	logic [SQ_W-1:0]          sq_s2 [3];
	logic signed [2*D_W-1:0]  dp_s2 [3];
	logic signed [2*D_W-1:0]  sq_c [3];
	dvec_t                    d_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = $signed(d_s1[i]) * $signed(d_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= sq_c[i][SQ_W-1:0];
				dp_s2[i] <= $signed(d_s1[i]) * $signed(w_s1[i]);
			end
			d_s2 <= d_s1;
		end
	end

	// stage 3: squared length and dot product
	logic [N_W-1:0]   n_s3;
	logic [DOT_W-1:0] dot_s3;
	dvec_t            d_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3   <= N_W'(sq_s2[0]) + N_W'(sq_s2[1]) + N_W'(sq_s2[2]);
			dot_s3 <= DOT_W'(dp_s2[0]) + DOT_W'(dp_s2[1]) + DOT_W'(dp_s2[2]);
			d_s3   <= d_s2;
		end
	end

	// square root, one root bit per stage; index is the stage in the unit
	sqr_t                sqr_s  [SQ_N];
	sqr_t                sqr_in [SQ_N];
	sqr_t                sqr_nx [SQ_N];
	logic [SQ_REM_W+1:0] sqr_sh [SQ_N];
	logic [SQ_REM_W+1:0] sqr_tr [SQ_N];
	logic                sqr_ge [SQ_N];

	always_comb begin
		sqr_in[0].rem  = '0;
		sqr_in[0].root = '0;
		sqr_in[0].nsh  = n_s3;
		sqr_in[0].dot  = dot_s3;
		sqr_in[0].d    = d_s3;
		for (int k = 1; k < SQ_N; k++) begin
			sqr_in[k] = sqr_s[k-1];
		end
		for (int k = 0; k < SQ_N; k++) begin
			sqr_sh[k] = {sqr_in[k].rem, sqr_in[k].nsh[N_W-1 -: 2]};
			sqr_tr[k] = (SQ_REM_W+2)'({sqr_in[k].root, 2'b01});
			sqr_ge[k] = sqr_sh[k] >= sqr_tr[k];
			sqr_nx[k]      = sqr_in[k];
			sqr_nx[k].rem  = sqr_ge[k] ? SQ_REM_W'(sqr_sh[k] - sqr_tr[k])
				: SQ_REM_W'(sqr_sh[k]);
			sqr_nx[k].root = {sqr_in[k].root[L_W-2:0], sqr_ge[k]};
			sqr_nx[k].nsh  = sqr_in[k].nsh << 2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_N; k++) begin
				sqr_s[k] <= sqr_nx[k];
			end
		end
	end

	// damping rate divider: |d . w| / L, one quotient bit per stage
	rdv_t             rdv_s  [RQ_W];
	rdv_t             rdv_in [RQ_W];
	rdv_t             rdv_nx [RQ_W];
	logic [L_W:0]     rdv_sh [RQ_W];
	logic             rdv_ge [RQ_W];
	logic [DOT_W-1:0] dmag_c;
	logic             dneg_c;

	always_comb begin
		dneg_c = sqr_s[SQ_N-1].dot[DOT_W-1];
		dmag_c = dneg_c ? DOT_W'(-sqr_s[SQ_N-1].dot) : sqr_s[SQ_N-1].dot;
		rdv_in[0].rem = L_W'(dmag_c >> RQ_W);
		rdv_in[0].lo  = dmag_c[RQ_W-1:0];
		rdv_in[0].q   = '0;
		rdv_in[0].len = sqr_s[SQ_N-1].root;
		rdv_in[0].neg = dneg_c;
		rdv_in[0].d   = sqr_s[SQ_N-1].d;
		for (int k = 1; k < RQ_W; k++) begin
			rdv_in[k] = rdv_s[k-1];
		end
		for (int k = 0; k < RQ_W; k++) begin
			rdv_sh[k] = {rdv_in[k].rem, rdv_in[k].lo[RQ_W-1]};
			rdv_ge[k] = rdv_sh[k] >= (L_W+1)'(rdv_in[k].len);
			rdv_nx[k]     = rdv_in[k];
			rdv_nx[k].rem = rdv_ge[k] ? L_W'(rdv_sh[k] - (L_W+1)'(rdv_in[k].len))
				: L_W'(rdv_sh[k]);
			rdv_nx[k].q   = {rdv_in[k].q[RQ_W-2:0], rdv_ge[k]};
			rdv_nx[k].lo  = rdv_in[k].lo << 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RQ_W; k++) begin
				rdv_s[k] <= rdv_nx[k];
			end
		end
	end

	// stage 5: stiffness and damping products
	logic signed [RQ_W:0]   rate_c;
	logic signed [L_W:0]    stretch_c;
	logic signed [PK_W-1:0] pk_s5;
	logic signed [PD_W-1:0] pd_s5;
	logic [L_W-1:0]         len_s5;
	dvec_t                  d_s5;

	always_comb begin
		rate_c    = rdv_s[RQ_W-1].neg ? -$signed({1'b0, rdv_s[RQ_W-1].q})
			: $signed({1'b0, rdv_s[RQ_W-1].q});
		stretch_c = $signed((L_W+1)'(rdv_s[RQ_W-1].len) - (L_W+1)'(rest_q));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pk_s5  <= $signed({1'b0, stiff_q}) * stretch_c;
			pd_s5  <= $signed({1'b0, damp_q}) * rate_c;
			len_s5 <= rdv_s[RQ_W-1].len;
			d_s5   <= rdv_s[RQ_W-1].d;
		end
	end

	// stage 6: scalar s, split into sign and magnitude
	logic signed [ACC_W-1:0] acc_c;
	logic signed [S_W-1:0]   s_c;
	logic [S_W-1:0]          smag_s6;
	logic                    sneg_s6;
	logic [L_W-1:0]          len_s6;
	dvec_t                   d_s6;

	always_comb begin
		acc_c = ACC_W'(pk_s5) + ACC_W'(pd_s5);
		s_c   = acc_c[ACC_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smag_s6 <= s_c[S_W-1] ? S_W'(-s_c) : S_W'(s_c);
			sneg_s6 <= s_c[S_W-1];
			len_s6  <= len_s5;
			d_s6    <= d_s5;
		end
	end

	// stage 7: partial products of |s| * |d|
	logic [SL+D_W-1:0] pl_s7 [3];
	logic [SH+D_W-1:0] ph_s7 [3];
	logic [D_W-1:0]    dm_c [3];
	logic [2:0]        neg_s7;
	logic [L_W-1:0]    len_s7;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dm_c[i] = d_s6[i][D_W-1] ? D_W'(-d_s6[i]) : d_s6[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pl_s7[i]  <= smag_s6[SL-1:0] * dm_c[i];
				ph_s7[i]  <= smag_s6[S_W-1:SL] * dm_c[i];
				neg_s7[i] <= sneg_s6 ^ d_s6[i][D_W-1];
			end
			len_s7 <= len_s6;
		end
	end

	// stage 8: full products
	logic [P_W-1:0] p_s8 [3];
	logic [2:0]     neg_s8;
	logic [L_W-1:0] len_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s8[i] <= (P_W'(ph_s7[i]) << SL) + P_W'(pl_s7[i]);
			end
			neg_s8 <= neg_s7;
			len_s8 <= len_s7;
		end
	end

	// force divider, three lanes, one quotient bit per stage
	fdv_t             fdv_s  [FQ_W];
	fdv_t             fdv_in [FQ_W];
	fdv_t             fdv_nx [FQ_W];
	logic [L_W:0]     fdv_sh [FQ_W][3];
	logic             fdv_ge [FQ_W][3];
	logic [P_W-33:0]  fhi_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fhi_c[i] = p_s8[i][P_W-1:FQ_W];
			fdv_in[0].ln[i].rem = fhi_c[i][L_W-1:0];
			fdv_in[0].ln[i].lo  = p_s8[i][FQ_W-1:0];
			fdv_in[0].ln[i].q   = '0;
			fdv_in[0].ln[i].ovf = fhi_c[i] >= (P_W-FQ_W)'(len_s8);
			fdv_in[0].ln[i].neg = neg_s8[i];
		end
		fdv_in[0].len = len_s8;
		for (int k = 1; k < FQ_W; k++) begin
			fdv_in[k] = fdv_s[k-1];
		end
		for (int k = 0; k < FQ_W; k++) begin
			fdv_nx[k] = fdv_in[k];
			for (int i = 0; i < 3; i++) begin
				fdv_sh[k][i] = {fdv_in[k].ln[i].rem, fdv_in[k].ln[i].lo[FQ_W-1]};
				fdv_ge[k][i] = fdv_sh[k][i] >= (L_W+1)'(fdv_in[k].len);
				fdv_nx[k].ln[i].rem = fdv_ge[k][i]
					? L_W'(fdv_sh[k][i] - (L_W+1)'(fdv_in[k].len))
					: L_W'(fdv_sh[k][i]);
				fdv_nx[k].ln[i].q   = {fdv_in[k].ln[i].q[FQ_W-2:0], fdv_ge[k][i]};
				fdv_nx[k].ln[i].lo  = fdv_in[k].ln[i].lo << 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < FQ_W; k++) begin
				fdv_s[k] <= fdv_nx[k];
			end
		end
	end

	// sign, clamp and the coincident case
	logic [FQ_W-1:0] fo_c [3];
	logic            big_c [3];
	logic            sat_c, zl_c;
	logic [FQ_W-1:0] force_q [3];
	logic            zl_q, sat_q;

	always_comb begin
		sat_c = 1'b0;
		zl_c  = fdv_s[FQ_W-1].len == '0;
		for (int i = 0; i < 3; i++) begin
			big_c[i] = fdv_s[FQ_W-1].ln[i].neg ? (fdv_s[FQ_W-1].ln[i].q > FORCE_MIN)
				: fdv_s[FQ_W-1].ln[i].q[FQ_W-1];
			if (fdv_s[FQ_W-1].ln[i].ovf || big_c[i]) begin
				fo_c[i] = fdv_s[FQ_W-1].ln[i].neg ? FORCE_MIN : FORCE_MAX;
				sat_c   = 1'b1;
			end else begin
				fo_c[i] = fdv_s[FQ_W-1].ln[i].neg ? FQ_W'(-fdv_s[FQ_W-1].ln[i].q)
					: fdv_s[FQ_W-1].ln[i].q;
			end
			if (zl_c) begin
				fo_c[i] = '0;
			end
		end
		if (zl_c) begin
			sat_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				force_q[i] <= fo_c[i];
			end
			zl_q  <= zl_c;
			sat_q <= sat_c;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {force_q[2], force_q[1], force_q[0]};
	assign m_tuser  = {sat_q, zl_q};

	// checks
	`DSF_ASSERT_NOW(a_zero_no_sat, m_tvalid && m_tuser[0], !m_tuser[1] && m_tdata == '0, "zero length beat carries force or saturation")
	`DSF_ASSERT_NOW(a_sat_bound, m_tvalid && m_tuser[1], m_tdata[31:0] == FORCE_MAX || m_tdata[31:0] == FORCE_MIN || m_tdata[63:32] == FORCE_MAX || m_tdata[63:32] == FORCE_MIN || m_tdata[95:64] == FORCE_MAX || m_tdata[95:64] == FORCE_MIN, "saturated beat has no clamped component")
	`DSF_ASSERT_NOW(a_sqrt_rem, sqr_v_s[SQ_N-1], sqr_s[SQ_N-1].rem <= (SQ_REM_W'(sqr_s[SQ_N-1].root) << 1), "square root remainder out of range")
	`DSF_ASSERT_NOW(a_rate_rem, rdv_v_s[RQ_W-1] && rdv_s[RQ_W-1].len != '0, rdv_s[RQ_W-1].rem < rdv_s[RQ_W-1].len, "rate divider remainder not below length")
	`DSF_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid, "output beat dropped during stall")

endmodule

@@ dv/damped_spring_force_test.sv @@
module damped_spring_force_test;
	import dsf_pkg::*;

	localparam int unsigned FRAC = 16;
	localparam int unsigned PHASE_BEATS = 256;

	// expected force beat
	typedef struct {
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
		logic        zero_len;
		logic        sat;
	} force_beat_t;

	// spring force predictor and queue of pending forces
	class spring_scoreboard;
		logic [30:0] rest;
		logic [30:0] stiff;
		logic [30:0] damp;
		force_beat_t pending_forces[$];
		int          errors;

		function new();
			rest = REST_RESET;
			stiff = STIFF_RESET;
			damp = DAMP_RESET;
			errors = 0;
		endfunction

		function void write_reg(int idx, logic [31:0] val);
			if (idx == REG_REST_LENGTH) begin
				rest = val[30:0];
			end else if (idx == REG_STIFFNESS) begin
				stiff = val[30:0];
			end else if (idx == REG_DAMPING) begin
				damp = val[30:0];
			end
		endfunction

		// predict the force for one accepted input beat
		function void note_input(logic [383:0] dat);
			logic signed [31:0]  pa, pb, va, vb;
			logic signed [127:0] dd[3];
			logic signed [127:0] ww, dot, len, rate, acc, s, q;
			logic [127:0]        len2, c, r;
			logic [31:0]         f[3];
			logic                sat;
			force_beat_t         e;
			int                  i, b;
			len2 = 0;
			dot = 0;
			sat = 0;
			for (i = 0; i < 3; i++) begin
				pa = dat[32*i +: 32];
				pb = dat[32*(3+i) +: 32];
				va = dat[32*(6+i) +: 32];
				vb = dat[32*(9+i) +: 32];
				dd[i] = pa;
				dd[i] = dd[i] - pb;
				ww = va;
				ww = ww - vb;
				len2 = len2 + unsigned'(dd[i] * dd[i]);
				dot = dot + dd[i] * ww;
			end
			// floor square root of the squared length
			r = 0;
			for (b = 33; b >= 0; b--) begin
				c = r | (128'd1 << b);
				if (c * c <= len2) r = c;
			end
			if (r == 0) begin
				e.fx = 0; e.fy = 0; e.fz = 0; e.zero_len = 1; e.sat = 0;
			end else begin
				len = signed'(r);
				rate = dot / len;
				acc = signed'({97'd0, stiff}) * (len - signed'({97'd0, rest}))
					+ signed'({97'd0, damp}) * rate;
				s = acc >>> FRAC;
				for (i = 0; i < 3; i++) begin
					q = (s * dd[i]) / len;
					if (q > 128'sd2147483647) begin
						f[i] = FORCE_MAX; sat = 1;
					end else if (q < -128'sd2147483648) begin
						f[i] = FORCE_MIN; sat = 1;
					end else begin
						f[i] = q[31:0];
					end
				end
				e.fx = f[0]; e.fy = f[1]; e.fz = f[2]; e.zero_len = 0; e.sat = sat;
			end
			pending_forces.push_back(e);
		endfunction

		// compare one output beat with the oldest prediction
		function void check_result(logic [95:0] dat, logic [1:0] usr);
			force_beat_t e;
			if (pending_forces.size() == 0) begin
				$display("%0t unexpected beat: actual %h %b", $time, dat, usr);
				errors++;
				return;
			end
			e = pending_forces.pop_front();
			if (dat[31:0] !== e.fx) begin
				$display("%0t force_x expected %h actual %h", $time, e.fx, dat[31:0]);
				errors++;
			end
			if (dat[63:32] !== e.fy) begin
				$display("%0t force_y expected %h actual %h", $time, e.fy, dat[63:32]);
				errors++;
			end
			if (dat[95:64] !== e.fz) begin
				$display("%0t force_z expected %h actual %h", $time, e.fz, dat[95:64]);
				errors++;
			end
			if (usr[0] !== e.zero_len) begin
				$display("%0t zero_length expected %b actual %b", $time, e.zero_len, usr[0]);
				errors++;
			end
			if (usr[1] !== e.sat) begin
				$display("%0t saturated expected %b actual %b", $time, e.sat, usr[1]);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         psel = 0;
	logic         penable = 0;
	logic         pwrite = 0;
	logic [3:0]   paddr = 0;
	logic [31:0]  pwdata = 0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 0;
	logic         s_tready;
	// first_pos_x/y/z, second_pos_x/y/z, first_vel_x/y/z, second_vel_x/y/z
	logic [383:0] s_tdata = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	// force_x, force_y, force_z
	logic [95:0]  m_tdata;
	// zero_length, saturated
	logic [1:0]   m_tuser;

	logic             no_idle = 0;
	spring_scoreboard sb = new();

	damped_spring_force #(.FRAC_BITS(FRAC)) u_dut (.*);

	always #6 clk = ~clk;

	// hard limit on run time
	initial begin
		#(12 * 400000);
		$display("FAIL");
		$finish;
	end

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(99) < 31);
	endfunction

	// output side: random backpressure, check at the rising edge
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
			@(negedge clk);
			m_tready = !idle_now();
		end
	end

	task automatic reg_write(logic [3:0] addr, logic [31:0] val);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = val;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		if (pready && addr[1:0] == 2'd0) sb.write_reg(addr >> 2, val);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	// send one input beat; called at a falling edge, returns at one
	task automatic send_pair(logic [383:0] dat);
		while (idle_now()) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = dat;
		do @(posedge clk); while (!s_tready);
		sb.note_input(dat);
		@(negedge clk);
	endtask

	// called at a falling edge; drop valid at once so no beat repeats
	task automatic wait_drained();
		s_tvalid = 0;
		while (sb.pending_forces.size() > 0) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(32'h0003_ffff) - 32'h0002_0000;
			2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return $urandom_range(32'h00ff_ffff) - 32'h0080_0000;
		endcase
	endfunction

	function automatic logic [383:0] rand_pair();
		logic [383:0] v;
		int           mode, i;
		mode = $urandom_range(3);
		for (i = 0; i < 12; i++) v[32*i +: 32] = rand_coord(mode);
		// coincident positions now and then
		if ($urandom_range(15) == 0) v[191:96] = v[95:0];
		if ($urandom_range(7) == 0) v[383:192] = {6{$urandom()}};
		return v;
	endfunction

	function automatic logic [383:0] pack_pair(logic [31:0] p0, logic [31:0] p1,
		logic [31:0] v0, logic [31:0] v1);
		return {{3{v1}}, {3{v0}}, {3{p1}}, {3{p0}}};
	endfunction

	task automatic random_phase(int beats);
		int n;
		for (n = 0; n < beats; n++) begin
			// a long stretch without idling in the middle of each phase
			no_idle = (n >= beats / 3) && (n < beats / 2);
			send_pair(rand_pair());
		end
		no_idle = 0;
		wait_drained();
	endtask

	// main sequence
	initial begin
		logic [383:0] v;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes and coincident positions
		send_pair('0);
		send_pair(pack_pair(32'h0001_0000, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000));
		send_pair(pack_pair(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0));
		send_pair(pack_pair(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
		send_pair(pack_pair(32'h0001_0000, 32'h0, 32'h0, 32'h0));
		send_pair(pack_pair(32'h0, 32'h0000_0001, 32'hffff_ffff, 32'h0));
		v = '0; v[31:0] = 32'h0002_0000;
		send_pair(v);
		v = '0; v[63:32] = 32'hfffe_0000; v[223:192] = 32'h0001_0000;
		send_pair(v);
		v = '0; v[95:64] = 32'h7fff_ffff; v[191:160] = 32'h8000_0000;
		send_pair(v);
		wait_drained();

		reg_write(4'd0, 32'h0);
		reg_write(4'd4, 32'hffff_ffff);
		reg_write(4'd8, 32'hffff_ffff);
		reg_write(4'd12, 32'h1234_5678);
		send_pair(pack_pair(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0));
		send_pair(pack_pair(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
		send_pair(pack_pair(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
		send_pair(pack_pair(32'h0000_0001, 32'h0, 32'h8000_0000, 32'h7fff_ffff));
		send_pair(pack_pair(32'h1234_5678, 32'h1234_5678, 32'h7fff_ffff, 32'h0));
		wait_drained();

		// random phases under several spring settings
		reg_write(4'd0, 32'h0001_0000);
		reg_write(4'd4, 32'h0001_0000);
		reg_write(4'd8, 32'h0);
		random_phase(PHASE_BEATS);
		reg_write(4'd0, 32'h7fff_ffff);
		reg_write(4'd4, 32'h7fff_ffff);
		reg_write(4'd8, 32'h7fff_ffff);
		random_phase(PHASE_BEATS);
		reg_write(4'd0, 32'h0);
		reg_write(4'd4, 32'h0);
		reg_write(4'd8, 32'h0000_8000);
		random_phase(PHASE_BEATS);
		reg_write(4'd0, $urandom());
		reg_write(4'd4, $urandom_range(32'h000f_ffff));
		reg_write(4'd8, $urandom_range(32'h000f_ffff));
		random_phase(PHASE_BEATS);
		reg_write(4'd0, $urandom());
		reg_write(4'd4, $urandom());
		reg_write(4'd8, $urandom());
		random_phase(PHASE_BEATS);

		// let the pipeline settle past its latency
		repeat (150) @(posedge clk);
		if (sb.errors == 0 && sb.pending_forces.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+src
src/dsf_pkg.sv
src/damped_spring_force.sv
dv/damped_spring_force_test.sv
